// ===== hw/rtl/quaternion_point_transform_top_assert.svh =====
// Assertion macros for the quaternion point transform block.
// Expects signals named clock and reset in the module that uses them.
`ifndef QUATERNION_POINT_TRANSFORM_TOP_ASSERT_SVH
`define QUATERNION_POINT_TRANSFORM_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define QPT_ASSERT_IMPL(lbl, cond, conseq, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define QPT_ASSERT_NEXT(lbl, cond, conseq, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// ===== hw/rtl/qpt_pkg.sv =====
// Shared types, widths and codes for the quaternion point transform.
// No dependencies; imported by every module and interface of the block.
package qpt_pkg;

   localparam int QUAT_W      = 16;
   localparam int COORD_W     = 32;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int QSIGN_W     = QUAT_W + 1;
   localparam int PROD1_W     = DIFF_W + QSIGN_W;
   localparam int SUM1_W      = PROD1_W + 2;
   localparam int ROUND1_SH   = 6;
   localparam int HALF_W      = SUM1_W - ROUND1_SH;
   localparam int PROD2_W     = HALF_W + QSIGN_W;
   localparam int SUM2_W      = PROD2_W + 2;
   localparam int ROUND2_SH   = 22;
   localparam int ROT_W       = SUM2_W - ROUND2_SH;
   localparam int FINAL_W     = ROT_W + 1;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef logic signed [QUAT_W-1:0]  quat_comp_type;
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [QSIGN_W-1:0] qsign_type;
   typedef logic signed [PROD1_W-1:0] prod1_type;
   typedef logic signed [SUM1_W-1:0]  sum1_type;
   typedef logic signed [HALF_W-1:0]  half_comp_type;
   typedef logic signed [PROD2_W-1:0] prod2_type;
   typedef logic signed [SUM2_W-1:0]  sum2_type;
   typedef logic signed [ROT_W-1:0]   rot_type;
   typedef logic signed [FINAL_W-1:0] final_type;

   localparam quat_comp_type QUAT_ONE    = quat_comp_type'(2 ** (QUAT_W - 2));
   localparam sum1_type      ROUND1_BIAS = sum1_type'(2 ** (ROUND1_SH - 1));
   localparam sum2_type      ROUND2_BIAS = sum2_type'(2 ** (ROUND2_SH - 1));

   typedef enum logic [1:0] {
      MODE_POINT_FWD = 2'd0,
      MODE_POINT_INV = 2'd1,
      MODE_DIR_FWD   = 2'd2,
      MODE_DIR_INV   = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QUAT_X  = 3'd0,
      CSR_QUAT_Y  = 3'd1,
      CSR_QUAT_Z  = 3'd2,
      CSR_QUAT_W  = 3'd3,
      CSR_SHIFT_X = 3'd4,
      CSR_SHIFT_Y = 3'd5,
      CSR_SHIFT_Z = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic     valid;
      mode_type mode;
   } pipe_ctl_type;

   typedef struct packed {
      quat_comp_type x;
      quat_comp_type y;
      quat_comp_type z;
      quat_comp_type w;
   } quat_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec_type;

   // q * v product, rounded to Q24
   typedef struct packed {
      half_comp_type x;
      half_comp_type y;
      half_comp_type z;
      half_comp_type w;
   } half_type;

   function automatic logic is_inverse(mode_type m);
      return (m == MODE_POINT_INV) || (m == MODE_DIR_INV);
   endfunction

   // sign-extend one quaternion component and negate it for the conjugate
   function automatic qsign_type signed_comp(quat_comp_type c, logic neg);
      qsign_type ext;
      ext = QSIGN_W'(c);
      return neg ? -ext : ext;
   endfunction

endpackage

// ===== hw/rtl/qpt_req_if.sv =====
// Input channel of the quaternion point transform: mode and vector.
// Depends on qpt_pkg.
interface qpt_req_if import qpt_pkg::*; ();
   logic      valid;
   logic      ready;
   mode_type  mode;
   coord_type in_x;
   coord_type in_y;
   coord_type in_z;

   modport source (output valid, mode, in_x, in_y, in_z, input ready);
   modport sink   (input valid, mode, in_x, in_y, in_z, output ready);
endinterface

// ===== hw/rtl/qpt_rsp_if.sv =====
// Result channel of the quaternion point transform: vector and clamp flag.
// Depends on qpt_pkg.
interface qpt_rsp_if import qpt_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   coord_type out_z;
   logic      saturated;

   modport source (output valid, out_x, out_y, out_z, saturated, input ready);
   modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

// ===== hw/rtl/quaternion_point_transform_top.sv =====
// Quaternion point transform: rotates Q16.16 vectors by a Q1.14 quaternion and,
// in the point modes, applies a translation, per item in one of four modes. It takes
// one vector per cycle while the result side does not stall, through six pipeline stages
// (shift removal, two multiply ranks, two sum-and-round ranks, translate-and-clamp).
// A stall on the result side holds the whole pipeline in place; no item is lost.
// Write the transform registers only while no item is in flight.
// Depends on qpt_pkg, qpt_req_if, qpt_rsp_if, qpt_front, qpt_back and the assert header.
`include "quaternion_point_transform_top_assert.svh"

module quaternion_point_transform_top import qpt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   qpt_req_if.sink                req_chan,
   qpt_rsp_if.source              rsp_chan
);

   localparam coord_type COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   quat_type     quat_ff;
   vec_type      shift_ff;
   logic         advance;
   pipe_ctl_type in_ctl, mid_ctl;
   vec_type      in_vec, out_vec;
   half_type     mid_half;
   logic         out_valid, out_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff.x  <= '0;
         quat_ff.y  <= '0;
         quat_ff.z  <= '0;
         quat_ff.w  <= QUAT_ONE;
         shift_ff.x <= '0;
         shift_ff.y <= '0;
         shift_ff.z <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_QUAT_X:  quat_ff.x  <= csr_data[QUAT_W-1:0];
            CSR_QUAT_Y:  quat_ff.y  <= csr_data[QUAT_W-1:0];
            CSR_QUAT_Z:  quat_ff.z  <= csr_data[QUAT_W-1:0];
            CSR_QUAT_W:  quat_ff.w  <= csr_data[QUAT_W-1:0];
            CSR_SHIFT_X: shift_ff.x <= csr_data[COORD_W-1:0];
            CSR_SHIFT_Y: shift_ff.y <= csr_data[COORD_W-1:0];
            CSR_SHIFT_Z: shift_ff.z <= csr_data[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless the output register holds an untaken result
   assign advance        = !out_valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   assign in_ctl.valid = req_chan.valid;
   assign in_ctl.mode  = req_chan.mode;
   assign in_vec.x     = req_chan.in_x;
   assign in_vec.y     = req_chan.in_y;
   assign in_vec.z     = req_chan.in_z;

   qpt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_ctl   (in_ctl),
      .in_vec   (in_vec),
      .quat     (quat_ff),
      .shift    (shift_ff),
      .out_ctl  (mid_ctl),
      .out_half (mid_half)
   );

   qpt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_ctl    (mid_ctl),
      .in_half   (mid_half),
      .quat      (quat_ff),
      .shift     (shift_ff),
      .out_valid (out_valid),
      .out_vec   (out_vec),
      .out_sat   (out_sat)
   );

   assign rsp_chan.valid     = out_valid;
   assign rsp_chan.out_x     = out_vec.x;
   assign rsp_chan.out_y     = out_vec.y;
   assign rsp_chan.out_z     = out_vec.z;
   assign rsp_chan.saturated = out_sat;

   `QPT_ASSERT_IMPL(a_ready_when_empty, !rsp_chan.valid, req_chan.ready, "input blocked with empty output")
   `QPT_ASSERT_IMPL(a_stall_blocks_input, rsp_chan.valid && !rsp_chan.ready, !req_chan.ready, "input taken during output stall")
   `QPT_ASSERT_IMPL(a_sat_at_limit, rsp_chan.valid && rsp_chan.saturated, (rsp_chan.out_x == COORD_MAX) || (rsp_chan.out_x == COORD_MIN) || (rsp_chan.out_y == COORD_MAX) || (rsp_chan.out_y == COORD_MIN) || (rsp_chan.out_z == COORD_MAX) || (rsp_chan.out_z == COORD_MIN), "saturated flag without clamped component")
   `QPT_ASSERT_NEXT(a_quat_w_write, csr_wr_en && (csr_index == CSR_QUAT_W), quat_ff.w == $past(csr_data[QUAT_W-1:0]), "quat_w write not taken")

endmodule

// ===== hw/rtl/qpt_front.sv =====
// First half of the transform pipeline: optional shift removal and q * v.
// Three register stages; depends on qpt_pkg.
module qpt_front import qpt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  pipe_ctl_type in_ctl,
   input  vec_type      in_vec,
   input  quat_type     quat,
   input  vec_type      shift,
   output pipe_ctl_type out_ctl,
   output half_type     out_half
);

   pipe_ctl_type ctl1_ff, ctl2_ff, ctl3_ff;
   diff_type     p_in [3];
   diff_type     p_ff [3];
   qsign_type    ax, ay, az, aw;
   prod1_type    prod_in [4][3];
   prod1_type    prod_ff [4][3];
   sum1_type     sum_in [4];
   sum1_type     rnd [4];
   half_type     half_in, half_ff;

   // stage 1: inverse point mode removes the translation first
   always_comb begin
      p_in[0] = DIFF_W'(in_vec.x);
      p_in[1] = DIFF_W'(in_vec.y);
      p_in[2] = DIFF_W'(in_vec.z);
      if (in_ctl.mode == MODE_POINT_INV) begin
         p_in[0] = DIFF_W'(in_vec.x) - DIFF_W'(shift.x);
         p_in[1] = DIFF_W'(in_vec.y) - DIFF_W'(shift.y);
         p_in[2] = DIFF_W'(in_vec.z) - DIFF_W'(shift.z);
      end
   end

   // stage 2: partial products of q * v (conj(q) for inverse modes)
   always_comb begin
      ax = signed_comp(quat.x, is_inverse(ctl1_ff.mode));
      ay = signed_comp(quat.y, is_inverse(ctl1_ff.mode));
      az = signed_comp(quat.z, is_inverse(ctl1_ff.mode));
      aw = signed_comp(quat.w, 1'b0);
      prod_in[0][0] = PROD1_W'(ay) * PROD1_W'(p_ff[2]);
      prod_in[0][1] = PROD1_W'(az) * PROD1_W'(p_ff[1]);
      prod_in[0][2] = PROD1_W'(aw) * PROD1_W'(p_ff[0]);
      prod_in[1][0] = PROD1_W'(ax) * PROD1_W'(p_ff[2]);
      prod_in[1][1] = PROD1_W'(az) * PROD1_W'(p_ff[0]);
      prod_in[1][2] = PROD1_W'(aw) * PROD1_W'(p_ff[1]);
      prod_in[2][0] = PROD1_W'(ax) * PROD1_W'(p_ff[1]);
      prod_in[2][1] = PROD1_W'(ay) * PROD1_W'(p_ff[0]);
      prod_in[2][2] = PROD1_W'(aw) * PROD1_W'(p_ff[2]);
      prod_in[3][0] = PROD1_W'(ax) * PROD1_W'(p_ff[0]);
      prod_in[3][1] = PROD1_W'(ay) * PROD1_W'(p_ff[1]);
      prod_in[3][2] = PROD1_W'(az) * PROD1_W'(p_ff[2]);
   end

   // stage 3: sums, then round half up to Q24
   always_comb begin
      sum_in[0] = SUM1_W'(prod_ff[0][0]) - SUM1_W'(prod_ff[0][1]) + SUM1_W'(prod_ff[0][2]);
      sum_in[1] = SUM1_W'(prod_ff[1][1]) + SUM1_W'(prod_ff[1][2]) - SUM1_W'(prod_ff[1][0]);
      sum_in[2] = SUM1_W'(prod_ff[2][0]) - SUM1_W'(prod_ff[2][1]) + SUM1_W'(prod_ff[2][2]);
      sum_in[3] = -(SUM1_W'(prod_ff[3][0]) + SUM1_W'(prod_ff[3][1])
                    + SUM1_W'(prod_ff[3][2]));
      for (int i = 0; i < 4; i++) begin
         rnd[i] = sum_in[i] + ROUND1_BIAS;
      end
      half_in.x = rnd[0][SUM1_W-1:ROUND1_SH];
      half_in.y = rnd[1][SUM1_W-1:ROUND1_SH];
      half_in.z = rnd[2][SUM1_W-1:ROUND1_SH];
      half_in.w = rnd[3][SUM1_W-1:ROUND1_SH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
         ctl3_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl1_ff <= in_ctl;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff    <= p_in;
         prod_ff <= prod_in;
         half_ff <= half_in;
      end
   end

   assign out_ctl  = ctl3_ff;
   assign out_half = half_ff;

endmodule

// ===== hw/rtl/qpt_back.sv =====
// Second half of the transform pipeline: (q * v) * conj(q), translation, clamp.
// Three register stages, the last is the output register; depends on qpt_pkg.
module qpt_back import qpt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  pipe_ctl_type in_ctl,
   input  half_type     in_half,
   input  quat_type     quat,
   input  vec_type      shift,
   output logic         out_valid,
   output vec_type      out_vec,
   output logic         out_sat
);

   pipe_ctl_type ctl4_ff, ctl5_ff;
   qsign_type    bx, by, bz, bw;
   prod2_type    prod_in [3][4];
   prod2_type    prod_ff [3][4];
   sum2_type     sum_in [3];
   sum2_type     rnd [3];
   rot_type      rot_in [3];
   rot_type      rot_ff [3];
   final_type    fin [3];
   coord_type    clip [3];
   logic [2:0]   clip_sat;
   vec_type      out_vec_in, out_vec_ff;
   logic         out_sat_in, out_sat_ff, out_valid_ff;

   // stage 4: partial products against the conjugate side
   always_comb begin
      bx = signed_comp(quat.x, is_inverse(in_ctl.mode));
      by = signed_comp(quat.y, is_inverse(in_ctl.mode));
      bz = signed_comp(quat.z, is_inverse(in_ctl.mode));
      bw = signed_comp(quat.w, 1'b0);
      prod_in[0][0] = PROD2_W'(in_half.x) * PROD2_W'(bw);
      prod_in[0][1] = PROD2_W'(in_half.y) * PROD2_W'(bz);
      prod_in[0][2] = PROD2_W'(in_half.z) * PROD2_W'(by);
      prod_in[0][3] = PROD2_W'(in_half.w) * PROD2_W'(bx);
      prod_in[1][0] = PROD2_W'(in_half.x) * PROD2_W'(bz);
      prod_in[1][1] = PROD2_W'(in_half.y) * PROD2_W'(bw);
      prod_in[1][2] = PROD2_W'(in_half.z) * PROD2_W'(bx);
      prod_in[1][3] = PROD2_W'(in_half.w) * PROD2_W'(by);
      prod_in[2][0] = PROD2_W'(in_half.x) * PROD2_W'(by);
      prod_in[2][1] = PROD2_W'(in_half.y) * PROD2_W'(bx);
      prod_in[2][2] = PROD2_W'(in_half.z) * PROD2_W'(bw);
      prod_in[2][3] = PROD2_W'(in_half.w) * PROD2_W'(bz);
   end

   // stage 5: sums, then round half up to Q16
   always_comb begin
      sum_in[0] = SUM2_W'(prod_ff[0][0]) - SUM2_W'(prod_ff[0][1])
                + SUM2_W'(prod_ff[0][2]) - SUM2_W'(prod_ff[0][3]);
      sum_in[1] = SUM2_W'(prod_ff[1][0]) + SUM2_W'(prod_ff[1][1])
                - SUM2_W'(prod_ff[1][2]) - SUM2_W'(prod_ff[1][3]);
      sum_in[2] = SUM2_W'(prod_ff[2][1]) + SUM2_W'(prod_ff[2][2])
                - SUM2_W'(prod_ff[2][0]) - SUM2_W'(prod_ff[2][3]);
      for (int i = 0; i < 3; i++) begin
         rnd[i]    = sum_in[i] + ROUND2_BIAS;
         rot_in[i] = rnd[i][SUM2_W-1:ROUND2_SH];
      end
   end

   // stage 6: forward point mode adds the translation, then clamp to 32 bits
   always_comb begin
      fin[0] = FINAL_W'(rot_ff[0]);
      fin[1] = FINAL_W'(rot_ff[1]);
      fin[2] = FINAL_W'(rot_ff[2]);
      if (ctl5_ff.mode == MODE_POINT_FWD) begin
         fin[0] = FINAL_W'(rot_ff[0]) + FINAL_W'(shift.x);
         fin[1] = FINAL_W'(rot_ff[1]) + FINAL_W'(shift.y);
         fin[2] = FINAL_W'(rot_ff[2]) + FINAL_W'(shift.z);
      end
      for (int i = 0; i < 3; i++) begin
         // in range when all bits above the 32-bit sign agree with it
         clip_sat[i] = !((&fin[i][FINAL_W-1:COORD_W-1]) || !(|fin[i][FINAL_W-1:COORD_W-1]));
         clip[i] = clip_sat[i]
                 ? {fin[i][FINAL_W-1], {(COORD_W-1){~fin[i][FINAL_W-1]}}}
                 : fin[i][COORD_W-1:0];
      end
      out_vec_in.x = clip[0];
      out_vec_in.y = clip[1];
      out_vec_in.z = clip[2];
      out_sat_in   = |clip_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff.valid <= 1'b0;
         ctl5_ff.valid <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (advance) begin
         ctl4_ff      <= in_ctl;
         ctl5_ff      <= ctl4_ff;
         out_valid_ff <= ctl5_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff    <= prod_in;
         rot_ff     <= rot_in;
         out_vec_ff <= out_vec_in;
         out_sat_ff <= out_sat_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_vec   = out_vec_ff;
   assign out_sat   = out_sat_ff;

endmodule
